// ===== hw/rtl/scd_pkg.sv =====
// scd_pkg: shared types and constants for the serial command decoder
// holds opcodes, phase and action codes and the result word struct
// no dependencies
package scd_pkg;

  localparam int DIGITS_DEF = 8;

  // handshake bytes
  localparam logic [7:0] BYTE_HELLO   = 8'hff;
  localparam logic [7:0] BYTE_CONNECT = 8'hf1;

  // opcodes taken while awaiting an opcode
  localparam logic [7:0] OP_DIGITS      = 8'h80;
  localparam logic [7:0] OP_BUZZER_ON   = 8'h40;
  localparam logic [7:0] OP_BUZZER_OFF  = 8'h4f;
  localparam logic [7:0] OP_MEM_WRITE   = 8'h20;
  localparam logic [7:0] OP_MEM_READ    = 8'h60;
  localparam logic [7:0] OP_LED         = 8'h70;
  localparam logic [7:0] OP_RELOAD      = 8'h50;
  localparam logic [7:0] OP_VIBRATE_ON  = 8'hc0;
  localparam logic [7:0] OP_VIBRATE_OFF = 8'hcf;
  localparam logic [7:0] OP_FORWARD     = 8'he0;
  localparam logic [7:0] OP_HOST_COPY   = 8'he8;

  // trailers and terminators
  localparam logic [7:0] END_DIGITS    = 8'h8f;
  localparam logic [7:0] END_MEM_WRITE = 8'h2f;
  localparam logic [7:0] END_MEM_READ  = 8'h6f;
  localparam logic [7:0] END_RELOAD    = 8'h5f;

  typedef enum logic [1:0] {
    LINK_IDLE      = 2'd1,
    LINK_WAIT      = 2'd2,
    LINK_CONNECTED = 2'd3
  } link_t;

  typedef enum logic [3:0] {
    CMD_OPCODE   = 4'd1,
    CMD_DIGITS   = 4'd2,
    CMD_WR_ADDR  = 4'd3,
    CMD_WR_DATA  = 4'd4,
    CMD_WR_END   = 4'd5,
    CMD_LED      = 4'd6,
    CMD_RD_ADDR  = 4'd7,
    CMD_RD_END   = 4'd8,
    CMD_RL_HIGH  = 4'd9,
    CMD_RL_LOW   = 4'd10,
    CMD_RL_END   = 4'd11,
    CMD_FORWARD  = 4'd12
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_REPLY     = 3'd1,
    ACT_DIGIT     = 3'd2,
    ACT_MEM_WRITE = 3'd3,
    ACT_MEM_READ  = 3'd4,
    ACT_LED       = 3'd5,
    ACT_RELOAD    = 3'd6,
    ACT_FORWARD   = 3'd7
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [2:0]  digit_index;
    logic [7:0]  data_byte;
    logic [7:0]  mem_address;
    logic [15:0] reload_value;
    logic        buzzer_enabled;
    logic        vibrate_enabled;
    logic        forward_to_host;
    logic        connected;
  } result_t;

endpackage

// ===== hw/rtl/scd_decode.sv =====
// scd_decode: link handshake and command state machine
// holds all decoder state, gives the result word for the byte presented
// depends on scd_pkg
module scd_decode
  import scd_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output result_t    res
);

  localparam int CW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int XW = (CW > 3) ? CW : 3;

  link_t       link, link_next;
  cmd_t        cmd, cmd_next;
  logic [CW-1:0] digit_counter, digit_counter_next;
  logic [7:0]  pending_address, pending_address_next;
  logic [7:0]  pending_data, pending_data_next;
  logic [7:0]  reload_high, reload_high_next;
  logic [7:0]  reload_low, reload_low_next;
  logic        buzzer, buzzer_next;
  logic        vibrate, vibrate_next;
  logic        host_copy, host_copy_next;

  logic [CW:0] count_inc;
  logic [XW-1:0] count_ext;

  assign count_inc = {1'b0, digit_counter} + (CW+1)'(1);
  assign count_ext = XW'(digit_counter);

  always_ff @(posedge clk) begin
    if (rst) begin
      link            <= LINK_IDLE;
      cmd             <= CMD_OPCODE;
      digit_counter   <= '0;
      pending_address <= '0;
      pending_data    <= '0;
      reload_high     <= '0;
      reload_low      <= '0;
      buzzer          <= 1'b0;
      vibrate         <= 1'b0;
      host_copy       <= 1'b0;
    end else if (fire) begin
      link            <= link_next;
      cmd             <= cmd_next;
      digit_counter   <= digit_counter_next;
      pending_address <= pending_address_next;
      pending_data    <= pending_data_next;
      reload_high     <= reload_high_next;
      reload_low      <= reload_low_next;
      buzzer          <= buzzer_next;
      vibrate         <= vibrate_next;
      host_copy       <= host_copy_next;
    end
  end

  always_comb begin
    link_next            = link;
    cmd_next             = cmd;
    digit_counter_next   = digit_counter;
    pending_address_next = pending_address;
    pending_data_next    = pending_data;
    reload_high_next     = reload_high;
    reload_low_next      = reload_low;
    buzzer_next          = buzzer;
    vibrate_next         = vibrate;
    host_copy_next       = host_copy;
    res                  = '0;
    res.action           = ACT_NONE;

    if (link == LINK_CONNECTED) begin
      case (cmd)
        CMD_OPCODE: begin
          case (rx_byte)
            OP_DIGITS:      cmd_next = CMD_DIGITS;
            OP_BUZZER_ON:   buzzer_next = 1'b1;
            OP_BUZZER_OFF:  buzzer_next = 1'b0;
            OP_MEM_WRITE:   cmd_next = CMD_WR_ADDR;
            OP_MEM_READ:    cmd_next = CMD_RD_ADDR;
            OP_LED:         cmd_next = CMD_LED;
            OP_RELOAD:      cmd_next = CMD_RL_HIGH;
            OP_VIBRATE_ON:  vibrate_next = 1'b1;
            OP_VIBRATE_OFF: vibrate_next = 1'b0;
            OP_FORWARD:     cmd_next = CMD_FORWARD;
            OP_HOST_COPY:   host_copy_next = 1'b1;
            default:        ;
          endcase
        end
        CMD_DIGITS: begin
          if (rx_byte == END_DIGITS) begin
            cmd_next           = CMD_OPCODE;
            digit_counter_next = '0;
          end else begin
            res.action      = ACT_DIGIT;
            res.digit_index = count_ext[2:0];
            res.data_byte   = rx_byte;
            if (count_inc >= (CW+1)'(DIGITS)) begin
              cmd_next           = CMD_OPCODE;
              digit_counter_next = '0;
            end else begin
              digit_counter_next = count_inc[CW-1:0];
            end
          end
        end
        CMD_WR_ADDR: begin
          pending_address_next = rx_byte;
          cmd_next             = CMD_WR_DATA;
        end
        CMD_WR_DATA: begin
          pending_data_next = rx_byte;
          cmd_next          = CMD_WR_END;
        end
        CMD_WR_END: begin
          if (rx_byte == END_MEM_WRITE) begin
            res.action      = ACT_MEM_WRITE;
            res.mem_address = pending_address;
            res.data_byte   = pending_data;
          end
          cmd_next = CMD_OPCODE;
        end
        CMD_LED: begin
          res.action    = ACT_LED;
          res.data_byte = rx_byte;
          cmd_next      = CMD_OPCODE;
        end
        CMD_RD_ADDR: begin
          pending_address_next = rx_byte;
          cmd_next             = CMD_RD_END;
        end
        CMD_RD_END: begin
          if (rx_byte == END_MEM_READ) begin
            res.action      = ACT_MEM_READ;
            res.mem_address = pending_address;
          end
          cmd_next = CMD_OPCODE;
        end
        CMD_RL_HIGH: begin
          reload_high_next = rx_byte;
          cmd_next         = CMD_RL_LOW;
        end
        CMD_RL_LOW: begin
          reload_low_next = rx_byte;
          cmd_next        = CMD_RL_END;
        end
        CMD_RL_END: begin
          if (rx_byte == END_RELOAD) begin
            res.action       = ACT_RELOAD;
            res.reload_value = {reload_high, reload_low};
          end
          cmd_next = CMD_OPCODE;
        end
        CMD_FORWARD: begin
          // sticky: everything from here on goes to rs485
          res.action    = ACT_FORWARD;
          res.data_byte = rx_byte;
        end
        default: ;
      endcase
    end else begin
      if (rx_byte == BYTE_HELLO) begin
        link_next  = LINK_WAIT;
        res.action = ACT_REPLY;
      end else if (rx_byte == BYTE_CONNECT) begin
        link_next = (link == LINK_WAIT) ? LINK_CONNECTED : LINK_IDLE;
      end
    end

    res.buzzer_enabled  = buzzer_next;
    res.vibrate_enabled = vibrate_next;
    res.forward_to_host = host_copy_next;
    res.connected       = (link_next == LINK_CONNECTED);
  end

endmodule

// ===== hw/rtl/serial_command_decoder_top.sv =====
// serial_command_decoder_top: input register, decoder and result register
// depends on scd_pkg and scd_decode
//
//  channel | direction | handshake             | payload
//  in      | to block  | in_valid / in_stall   | rx_byte
//  out     | from block| out_valid / out_stall | action .. connected
//
// one byte per cycle sustained while out_stall is low; each byte goes from
// the input register through the single pass of the decoder into the
// result register
// rst is synchronous: clears the link and command state and both valid bits
// a stalled result holds, and the input register still fills behind it,
// so one more byte is taken while a result waits
module serial_command_decoder_top
  import scd_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [2:0]  digit_index,
  output logic [7:0]  data_byte,
  output logic [7:0]  mem_address,
  output logic [15:0] reload_value,
  output logic        buzzer_enabled,
  output logic        vibrate_enabled,
  output logic        forward_to_host,
  output logic        connected
);

  logic       in_full;
  logic [7:0] in_byte;
  logic       res_full;
  result_t    res_word;
  result_t    dec_res;
  logic       advance;

  // byte moves into the decoder when the result slot is free or emptying
  assign advance  = in_full && (!res_full || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      res_full <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        res_full <= 1'b1;
      end else if (!out_stall) begin
        res_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
    if (advance) begin
      res_word <= dec_res;
    end
  end

  scd_decode #(
    .DIGITS(DIGITS)
  ) u_decode (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .rx_byte (in_byte),
    .res     (dec_res)
  );

  assign out_valid       = res_full;
  assign action          = res_word.action;
  assign digit_index     = res_word.digit_index;
  assign data_byte       = res_word.data_byte;
  assign mem_address     = res_word.mem_address;
  assign reload_value    = res_word.reload_value;
  assign buzzer_enabled  = res_word.buzzer_enabled;
  assign vibrate_enabled = res_word.vibrate_enabled;
  assign forward_to_host = res_word.forward_to_host;
  assign connected       = res_word.connected;

endmodule

// ===== sim/scd_decode_checker.sv =====
// scd_decode_checker: watches both channels of the serial command decoder and predicts each result
// keeps its own copy of the link and command state, compares every result word field by field
// depends on scd_pkg
module scd_decode_checker
  import scd_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  action,
  input  logic [2:0]  digit_index,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  mem_address,
  input  logic [15:0] reload_value,
  input  logic        buzzer_enabled,
  input  logic        vibrate_enabled,
  input  logic        forward_to_host,
  input  logic        connected,
  output int          fail_count,
  output int          outstanding,
  output int          words_checked,
  output logic [7:0]  actions_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  link_t      link_st;
  cmd_t       cmd_st;
  int         digit_cnt;
  logic [7:0] held_addr;
  logic [7:0] held_data;
  logic [7:0] reload_hi;
  logic [7:0] reload_lo;
  logic       buzz_flag;
  logic       vibrate_on;
  logic       host_copy_on;

  result_t    decoded_q[$];
  result_t    want;
  int         fails;
  int         checked;
  logic [7:0] seen;

  initial begin
    fail_count    = 0;
    outstanding   = 0;
    words_checked = 0;
    actions_seen  = '0;
    fails         = 0;
    checked       = 0;
    seen          = '0;
  end

  function automatic result_t decode_host_byte(logic [7:0] b);
    result_t r;
    r = '0;
    if (link_st == LINK_CONNECTED) begin
      case (cmd_st)
        CMD_OPCODE: begin
          case (b)
            OP_DIGITS:      cmd_st = CMD_DIGITS;
            OP_BUZZER_ON:   buzz_flag = 1'b1;
            OP_BUZZER_OFF:  buzz_flag = 1'b0;
            OP_MEM_WRITE:   cmd_st = CMD_WR_ADDR;
            OP_MEM_READ:    cmd_st = CMD_RD_ADDR;
            OP_LED:         cmd_st = CMD_LED;
            OP_RELOAD:      cmd_st = CMD_RL_HIGH;
            OP_VIBRATE_ON:  vibrate_on = 1'b1;
            OP_VIBRATE_OFF: vibrate_on = 1'b0;
            OP_FORWARD:     cmd_st = CMD_FORWARD;
            OP_HOST_COPY:   host_copy_on = 1'b1;
            default: ;
          endcase
        end
        CMD_DIGITS: begin
          if (b == END_DIGITS) begin
            cmd_st    = CMD_OPCODE;
            digit_cnt = 0;
          end else begin
            r.action      = ACT_DIGIT;
            r.digit_index = digit_cnt[2:0];
            r.data_byte   = b;
            digit_cnt++;
            if (digit_cnt >= DIGITS) begin
              cmd_st    = CMD_OPCODE;
              digit_cnt = 0;
            end
          end
        end
        CMD_WR_ADDR: begin
          held_addr = b;
          cmd_st    = CMD_WR_DATA;
        end
        CMD_WR_DATA: begin
          held_data = b;
          cmd_st    = CMD_WR_END;
        end
        CMD_WR_END: begin
          if (b == END_MEM_WRITE) begin
            r.action      = ACT_MEM_WRITE;
            r.mem_address = held_addr;
            r.data_byte   = held_data;
          end
          cmd_st = CMD_OPCODE;
        end
        CMD_LED: begin
          r.action    = ACT_LED;
          r.data_byte = b;
          cmd_st      = CMD_OPCODE;
        end
        CMD_RD_ADDR: begin
          held_addr = b;
          cmd_st    = CMD_RD_END;
        end
        CMD_RD_END: begin
          if (b == END_MEM_READ) begin
            r.action      = ACT_MEM_READ;
            r.mem_address = held_addr;
          end
          cmd_st = CMD_OPCODE;
        end
        CMD_RL_HIGH: begin
          reload_hi = b;
          cmd_st    = CMD_RL_LOW;
        end
        CMD_RL_LOW: begin
          reload_lo = b;
          cmd_st    = CMD_RL_END;
        end
        CMD_RL_END: begin
          if (b == END_RELOAD) begin
            r.action       = ACT_RELOAD;
            r.reload_value = {reload_hi, reload_lo};
          end
          cmd_st = CMD_OPCODE;
        end
        CMD_FORWARD: begin
          // sticky: everything from here on goes out to rs485
          r.action    = ACT_FORWARD;
          r.data_byte = b;
        end
        default: ;
      endcase
    end else begin
      if (b == BYTE_HELLO) begin
        link_st  = LINK_WAIT;
        r.action = ACT_REPLY;
      end else if (b == BYTE_CONNECT) begin
        link_st = (link_st == LINK_WAIT) ? LINK_CONNECTED : LINK_IDLE;
      end
    end
    r.buzzer_enabled  = buzz_flag;
    r.vibrate_enabled = vibrate_on;
    r.forward_to_host = host_copy_on;
    r.connected       = (link_st == LINK_CONNECTED);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      link_st      = LINK_IDLE;
      cmd_st       = CMD_OPCODE;
      digit_cnt    = 0;
      held_addr    = '0;
      held_data    = '0;
      reload_hi    = '0;
      reload_lo    = '0;
      buzz_flag    = 1'b0;
      vibrate_on   = 1'b0;
      host_copy_on = 1'b0;
      decoded_q.delete();
    end else begin
      if (in_valid && !in_stall)
        decoded_q.push_back(decode_host_byte(rx_byte));
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("result word 0x%0h arrived with nothing expected", action);
          fails++;
        end else begin
          want = decoded_q.pop_front();
          check_field("action", 16'(want.action), 16'(action));
          check_field("digit_index", 16'(want.digit_index), 16'(digit_index));
          check_field("data_byte", 16'(want.data_byte), 16'(data_byte));
          check_field("mem_address", 16'(want.mem_address), 16'(mem_address));
          check_field("reload_value", want.reload_value, reload_value);
          check_field("buzzer_enabled", 16'(want.buzzer_enabled), 16'(buzzer_enabled));
          check_field("vibrate_enabled", 16'(want.vibrate_enabled), 16'(vibrate_enabled));
          check_field("forward_to_host", 16'(want.forward_to_host), 16'(forward_to_host));
          check_field("connected", 16'(want.connected), 16'(connected));
          seen[want.action] = 1'b1;
          checked++;
        end
      end
    end
    fail_count    <= fails;
    outstanding   <= decoded_q.size();
    words_checked <= checked;
    actions_seen  <= seen;
  end

endmodule

// ===== sim/tb_top.sv =====
// tb_top: clock, reset and byte stimulus for serial_command_decoder_top, plus the verdict
// depends on scd_pkg, serial_command_decoder_top and scd_decode_checker
module tb_top
  import scd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_DIGITS     = DIGITS_DEF;
  localparam int LIMIT_CYCLES = 200000;
  localparam int PER_PHASE    = 330;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  action;
  logic [2:0]  digit_index;
  logic [7:0]  data_byte;
  logic [7:0]  mem_address;
  logic [15:0] reload_value;
  logic        buzzer_enabled;
  logic        vibrate_enabled;
  logic        forward_to_host;
  logic        connected;

  int          fail_count;
  int          outstanding;
  int          words_checked;
  logic [7:0]  actions_seen;

  int          send_idle_pct = 14;
  int          recv_idle_pct = 46;
  int          words_sent    = 0;
  int          directed_end;

  serial_command_decoder_top #(.DIGITS(N_DIGITS)) i_dut (
    .clk, .rst, .in_valid, .in_stall, .rx_byte, .out_valid, .out_stall,
    .action, .digit_index, .data_byte, .mem_address, .reload_value,
    .buzzer_enabled, .vibrate_enabled, .forward_to_host, .connected
  );

  scd_decode_checker #(.DIGITS(N_DIGITS)) i_checker (
    .clk, .rst, .in_valid, .in_stall, .rx_byte, .out_valid, .out_stall,
    .action, .digit_index, .data_byte, .mem_address, .reload_value,
    .buzzer_enabled, .vibrate_enabled, .forward_to_host, .connected,
    .fail_count, .outstanding, .words_checked, .actions_seen
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk)
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // one word per call, returns once the block has taken it
  task automatic send(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // random content, leaning on the extremes; the forward opcode is kept
  // out so the sticky mode is only entered at the very end
  function automatic logic [7:0] any_byte();
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hff;
    b = 8'($urandom_range(0, 255));
    if (b == OP_FORWARD) b = b ^ 8'h01;
    return b;
  endfunction

  task automatic send_command();
    int n;
    case ($urandom_range(0, 9))
      0, 1: begin
        n = $urandom_range(0, N_DIGITS);
        send(OP_DIGITS);
        repeat (n) send(any_byte());
        if (n < N_DIGITS && $urandom_range(0, 9) != 0) send(END_DIGITS);
      end
      2: begin
        send(OP_MEM_WRITE);
        send(any_byte());
        send(any_byte());
        send(($urandom_range(0, 5) != 0) ? END_MEM_WRITE : any_byte());
      end
      3: begin
        send(OP_MEM_READ);
        send(any_byte());
        send(($urandom_range(0, 5) != 0) ? END_MEM_READ : any_byte());
      end
      4: begin
        send(OP_LED);
        send(any_byte());
      end
      5: begin
        send(OP_RELOAD);
        send(any_byte());
        send(any_byte());
        send(($urandom_range(0, 5) != 0) ? END_RELOAD : any_byte());
      end
      6, 7: begin
        case ($urandom_range(0, 4))
          0: send(OP_BUZZER_ON);
          1: send(OP_BUZZER_OFF);
          2: send(OP_VIBRATE_ON);
          3: send(OP_VIBRATE_OFF);
          default: send(OP_HOST_COPY);
        endcase
      end
      default: repeat ($urandom_range(1, 3)) send(any_byte());
    endcase
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // handshake: stray bytes, connect without hello, hello, noise while waiting
    send(8'h00);
    send(BYTE_CONNECT);
    send(BYTE_HELLO);
    send(8'h5a);
    send(BYTE_CONNECT);
    // link is up: handshake bytes are now plain unknown opcodes
    send(BYTE_HELLO);
    send(BYTE_CONNECT);
    send(OP_BUZZER_ON);
    send(OP_VIBRATE_ON);
    send(OP_HOST_COPY);
    send(OP_BUZZER_OFF);
    send(OP_VIBRATE_OFF);
    send(OP_DIGITS);
    send(8'h00);
    send(8'hff);
    send(END_DIGITS);
    send(OP_MEM_WRITE);
    send(8'hff);
    send(8'h00);
    send(END_MEM_WRITE);
    send(OP_MEM_READ);
    send(8'h00);
    send(8'h00);
    send(OP_LED);
    send(OP_FORWARD);
    send(OP_RELOAD);
    send(8'hff);
    send(8'h00);
    send(END_RELOAD);
    directed_end = words_sent;

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 14; recv_idle_pct = 46; end
        1: begin send_idle_pct = 46; recv_idle_pct = 14; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      while (words_sent < directed_end + (ph + 1) * PER_PHASE) send_command();
    end

    // terminators walk any half-done command back to the opcode state
    send_idle_pct = 14;
    recv_idle_pct = 46;
    repeat (4) send(END_DIGITS);
    send(OP_FORWARD);
    repeat (40) send(8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d words sent, %0d result words checked, action codes seen %b",
             words_sent, words_checked, actions_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/scd_pkg.sv
hw/rtl/scd_decode.sv
hw/rtl/serial_command_decoder_top.sv
sim/scd_decode_checker.sv
sim/tb_top.sv
